>>> hdl/sadc_pkg.sv
// Shared types and constants of the set-associative data cache with victim cache.
`timescale 1ns / 1ps
package sadc_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_REFILL = 2'd3;

   localparam logic [1:0] KIND_RESP  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam int IDX_W = 16;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] address;
      logic [1:0]  size_code;
      logic [63:0] store_data;
      logic [63:0] refill_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        hit;
      logic [63:0] load_data;
      logic [63:0] mem_address;
      logic [63:0] mem_data;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      A_NONE, A_CLEAR, A_CAPT, A_FILL, A_FIN_ROW, A_FIN_SET, A_ROW_RD, A_ROW,
      A_TAG_RD, A_TAG_CMP, A_PICK, A_VPICK, A_OT_RD, A_OT, A_SW_RD, A_SW_WR,
      A_SW_FIN, A_EV_RD, A_EV_WR, A_EV_FIN, A_REQ, A_ACC_RD, A_ACC_WR
   } act_type;

   typedef struct packed {
      act_type          act;
      logic [IDX_W-1:0] idx;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic is_refill;
      logic pend_busy;
      logic fill_done;
      logic tag_match;
      logic vhit;
      logic displaced;
   } sts_type;

endpackage

>>> hdl/sadc_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module sadc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> hdl/sadc_ctrl.sv
// Sequencing state machine of the data cache.
`timescale 1ns / 1ps
module sadc_ctrl import sadc_pkg::*; #(
   parameter int SETS  = 32,
   parameter int WAYS  = 32,
   parameter int WORDS = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [23:0] {
      S_CLEAR   = 24'h000001, S_IDLE   = 24'h000002, S_CAPT   = 24'h000004,
      S_FILL    = 24'h000008, S_FILLCHK = 24'h000010, S_FIN_ROW = 24'h000020,
      S_FIN_SET = 24'h000040, S_ROW_RD = 24'h000080, S_ROW    = 24'h000100,
      S_TAG_RD  = 24'h000200, S_TAG_CMP = 24'h000400, S_PICK   = 24'h000800,
      S_VPICK   = 24'h001000, S_OT_RD  = 24'h002000, S_OT     = 24'h004000,
      S_SW_RD   = 24'h008000, S_SW_WR  = 24'h010000, S_SW_FIN = 24'h020000,
      S_EV_RD   = 24'h040000, S_EV_WR  = 24'h080000, S_EV_FIN = 24'h100000,
      S_REQ     = 24'h200000, S_ACC_RD = 24'h400000, S_ACC_WR = 24'h800000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.act  = A_NONE;
      cmd.idx  = cnt_ff;
      cmd.last = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.act = A_CLEAR;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(SETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.act  = A_CAPT;
               state_in = S_CAPT;
            end
         end
         S_CAPT: begin
            if (sts.is_refill) begin
               state_in = sts.pend_busy ? S_FILL : S_IDLE;
            end else begin
               state_in = sts.pend_busy ? S_IDLE : S_ROW_RD;
            end
         end
         S_FILL: begin
            cmd.act  = A_FILL;
            state_in = S_FILLCHK;
         end
         S_FILLCHK: state_in = sts.fill_done ? S_FIN_ROW : S_IDLE;
         S_FIN_ROW: begin
            cmd.act  = A_FIN_ROW;
            state_in = S_FIN_SET;
         end
         S_FIN_SET: begin
            cmd.act  = A_FIN_SET;
            state_in = S_ACC_RD;
         end
         S_ROW_RD: begin
            cmd.act  = A_ROW_RD;
            state_in = S_ROW;
         end
         S_ROW: begin
            cmd.act  = A_ROW;
            cnt_in   = '0;
            state_in = S_TAG_RD;
         end
         S_TAG_RD: begin
            cmd.act  = A_TAG_RD;
            state_in = S_TAG_CMP;
         end
         S_TAG_CMP: begin
            cmd.act = A_TAG_CMP;
            if (sts.tag_match) begin
               state_in = S_ACC_RD;
            end else if (cnt_ff == IDX_W'(WAYS - 1)) begin
               state_in = S_PICK;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_TAG_RD;
            end
         end
         S_PICK: begin
            cmd.act = A_PICK;
            cnt_in  = '0;
            if (sts.vhit) begin
               state_in = sts.displaced ? S_OT_RD : S_SW_RD;
            end else begin
               state_in = sts.displaced ? S_VPICK : S_REQ;
            end
         end
         S_VPICK: begin
            cmd.act  = A_VPICK;
            state_in = S_OT_RD;
         end
         S_OT_RD: begin
            cmd.act  = A_OT_RD;
            state_in = S_OT;
         end
         S_OT: begin
            cmd.act  = A_OT;
            cnt_in   = '0;
            state_in = sts.vhit ? S_SW_RD : S_EV_RD;
         end
         S_SW_RD: begin
            cmd.act  = A_SW_RD;
            state_in = S_SW_WR;
         end
         S_SW_WR: begin
            cmd.act = A_SW_WR;
            if (cnt_ff == IDX_W'(WORDS - 1)) begin
               state_in = S_SW_FIN;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_SW_FIN: begin
            cmd.act  = A_SW_FIN;
            state_in = S_ACC_RD;
         end
         S_EV_RD: begin
            cmd.act  = A_EV_RD;
            state_in = S_EV_WR;
         end
         S_EV_WR: begin
            cmd.act = A_EV_WR;
            if (cnt_ff == IDX_W'(WORDS - 1)) begin
               state_in = S_EV_FIN;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_EV_RD;
            end
         end
         S_EV_FIN: begin
            cmd.act  = A_EV_FIN;
            cnt_in   = '0;
            state_in = S_REQ;
         end
         S_REQ: begin
            cmd.act  = A_REQ;
            cmd.last = (cnt_ff == IDX_W'(WORDS - 1));
            if (cmd.last) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ACC_RD: begin
            cmd.act  = A_ACC_RD;
            state_in = S_ACC_WR;
         end
         S_ACC_WR: begin
            cmd.act  = A_ACC_WR;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

>>> hdl/sadc_dpath.sv
// Datapath of the data cache: memories, victim entries, LFSR and result register.
`timescale 1ns / 1ps
module sadc_dpath import sadc_pkg::*; #(
   parameter int SETS           = 32,
   parameter int WAYS           = 32,
   parameter int LINE_BYTES     = 16,
   parameter int VICTIM_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);
   localparam int WORDS = LINE_BYTES / 8;
   localparam int OFFW  = $clog2(LINE_BYTES);
   localparam int TAGW  = 64 - OFFW - $clog2(SETS);
   localparam int LAW   = 64 - OFFW;
   localparam int SETW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int VSW   = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
   localparam int WDW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PCW   = $clog2(WORDS + 1);
   localparam int LIW   = (SETS * WAYS > 1) ? $clog2(SETS * WAYS) : 1;
   localparam int DAW   = (SETS * WAYS * WORDS > 1) ? $clog2(SETS * WAYS * WORDS) : 1;
   localparam int VAW   = (VICTIM_ENTRIES * WORDS > 1) ?
                          $clog2(VICTIM_ENTRIES * WORDS) : 1;

   // Current access.
   logic [63:0]     cur_addr_ff, cur_sdata_ff, refill_ff;
   logic [1:0]      cur_op_ff, cur_size_ff;
   logic [WAYS-1:0] row_ff;
   logic            inv_any_ff, hitresp_ff, vhit_ff;
   logic [WW-1:0]   way_ff;
   logic [VSW-1:0]  vslot_ff;
   logic [TAGW-1:0] old_tag_ff;
   // Outstanding refill.
   logic            pend_busy_ff;
   logic [63:0]     paddr_ff, psv_ff;
   logic [1:0]      pop_ff, psize_ff;
   logic [WW-1:0]   pway_ff;
   logic [PCW-1:0]  pcount_ff;
   // Victim tags and control.
   logic [VICTIM_ENTRIES-1:0] vvalid_ff;
   logic [LAW-1:0]  vaddr_ff [VICTIM_ENTRIES];
   logic [15:0]     lfsr_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   // Memory ports.
   logic            vld_we, tag_we, dat_we, vic_we;
   logic [SETW-1:0] vld_waddr, vld_raddr;
   logic [WAYS-1:0] vld_wdata, vld_rdata;
   logic [LIW-1:0]  tag_waddr, tag_raddr;
   logic [TAGW-1:0] tag_wdata, tag_rdata;
   logic [DAW-1:0]  dat_waddr, dat_raddr;
   logic [63:0]     dat_wdata, dat_rdata;
   logic [VAW-1:0]  vic_waddr, vic_raddr;
   logic [63:0]     vic_wdata, vic_rdata;

   logic [63:0]     cur_line_no, old_line_no, mask, ext, merged;
   logic [SETW-1:0] cur_set, pset;
   logic [TAGW-1:0] cur_tag;
   logic [WDW-1:0]  cur_word, idx_word;
   logic [WW-1:0]   idx_way, inv_way;
   logic            inv_any, vfree_any, vmatch;
   logic [VSW-1:0]  vfree_slot, vmatch_slot;
   logic [5:0]      sh;
   logic [15:0]     lfsr_nx;

   function automatic logic [LIW-1:0] lidx(logic [SETW-1:0] s, logic [WW-1:0] w);
      return LIW'(int'(s) * WAYS + int'(w));
   endfunction

   function automatic logic [DAW-1:0] didx(logic [SETW-1:0] s, logic [WW-1:0] w,
                                           logic [WDW-1:0] d);
      return DAW'((int'(s) * WAYS + int'(w)) * WORDS + int'(d));
   endfunction

   function automatic logic [VAW-1:0] vidx(logic [VSW-1:0] v, logic [WDW-1:0] d);
      return VAW'(int'(v) * WORDS + int'(d));
   endfunction

   assign cur_line_no = cur_addr_ff / LINE_BYTES;
   assign cur_set     = SETW'(cur_line_no % SETS);
   assign cur_tag     = TAGW'(cur_line_no / SETS);
   assign pset        = SETW'((paddr_ff / LINE_BYTES) % SETS);
   assign cur_word    = WDW'((cur_addr_ff % LINE_BYTES) >> 3);
   assign idx_word    = WDW'(cmd.idx);
   assign idx_way     = WW'(cmd.idx);
   assign old_line_no = 64'(old_tag_ff) * SETS + 64'(cur_set);
   assign lfsr_nx     = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'h0000);

   // Sub-word access: offset aligned down to the access size.
   always_comb begin
      sh     = {cur_addr_ff[2:0] & ~3'((4'd1 << cur_size_ff) - 4'd1), 3'b000};
      mask   = (cur_size_ff == 2'd3) ? {64{1'b1}} :
               ((64'd1 << (7'd8 << cur_size_ff)) - 64'd1);
      ext    = (dat_rdata >> sh) & mask;
      merged = (dat_rdata & ~(mask << sh)) | ((cur_sdata_ff & mask) << sh);
   end

   always_comb begin
      inv_any = 1'b0;
      inv_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!vld_rdata[w]) begin
            inv_any = 1'b1;
            inv_way = WW'(w);
         end
      end
      vfree_any   = 1'b0;
      vfree_slot  = '0;
      vmatch      = 1'b0;
      vmatch_slot = '0;
      for (int v = VICTIM_ENTRIES - 1; v >= 0; v--) begin
         if (!vvalid_ff[v]) begin
            vfree_any  = 1'b1;
            vfree_slot = VSW'(v);
         end
         if (vvalid_ff[v] && vaddr_ff[v] == LAW'(cur_line_no)) begin
            vmatch      = 1'b1;
            vmatch_slot = VSW'(v);
         end
      end
   end

   // Memory port steering.
   always_comb begin
      vld_we    = 1'b0;
      vld_waddr = cur_set;
      vld_wdata = row_ff;
      vld_raddr = cur_set;
      tag_we    = 1'b0;
      tag_waddr = lidx(cur_set, way_ff);
      tag_wdata = cur_tag;
      tag_raddr = lidx(cur_set, way_ff);
      dat_we    = 1'b0;
      dat_waddr = didx(cur_set, way_ff, cur_word);
      dat_wdata = merged;
      dat_raddr = didx(cur_set, way_ff, cur_word);
      vic_we    = 1'b0;
      vic_waddr = vidx(vslot_ff, idx_word);
      vic_wdata = dat_rdata;
      vic_raddr = vidx(vslot_ff, idx_word);
      case (cmd.act)
         A_CLEAR: begin
            vld_we    = 1'b1;
            vld_waddr = SETW'(cmd.idx);
            vld_wdata = '0;
         end
         A_FILL: begin
            dat_we    = pend_busy_ff;
            dat_waddr = didx(pset, pway_ff, WDW'(pcount_ff));
            dat_wdata = refill_ff;
         end
         A_FIN_ROW: begin
            vld_raddr = pset;
            tag_we    = 1'b1;
            tag_waddr = lidx(pset, pway_ff);
            tag_wdata = TAGW'((paddr_ff / LINE_BYTES) / SETS);
         end
         A_FIN_SET: begin
            vld_we    = 1'b1;
            vld_wdata = vld_rdata | (WAYS'(1) << way_ff);
         end
         A_TAG_RD: tag_raddr = lidx(cur_set, idx_way);
         A_SW_RD, A_EV_RD: dat_raddr = didx(cur_set, way_ff, idx_word);
         A_SW_WR: begin
            dat_we    = 1'b1;
            dat_waddr = didx(cur_set, way_ff, idx_word);
            dat_wdata = vic_rdata;
            vic_we    = !inv_any_ff;
         end
         A_EV_WR: vic_we = 1'b1;
         A_SW_FIN: begin
            tag_we    = 1'b1;
            vld_we    = 1'b1;
            vld_wdata = row_ff | (WAYS'(1) << way_ff);
         end
         A_EV_FIN: begin
            vld_we    = 1'b1;
            vld_wdata = row_ff & ~(WAYS'(1) << way_ff);
         end
         A_ACC_WR: dat_we = (cur_op_ff != OP_LOAD);
         default: ;
      endcase
   end

   assign sts.is_refill = (cur_op_ff == OP_REFILL);
   assign sts.pend_busy = pend_busy_ff;
   assign sts.fill_done = (pcount_ff == PCW'(WORDS));
   assign sts.tag_match = row_ff[idx_way] && (tag_rdata == cur_tag);
   assign sts.vhit      = vhit_ff;
   assign sts.displaced = !inv_any_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_busy_ff <= 1'b0;
         vvalid_ff    <= '0;
         lfsr_ff      <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (cmd.act)
            A_FIN_SET: pend_busy_ff <= 1'b0;
            A_PICK: begin
               if (!inv_any_ff) begin
                  lfsr_ff <= lfsr_nx;
               end
            end
            A_VPICK: begin
               if (!vfree_any) begin
                  lfsr_ff <= lfsr_nx;
               end
            end
            A_SW_WR: rsp_valid_ff <= !inv_any_ff;
            A_EV_WR: rsp_valid_ff <= 1'b1;
            A_SW_FIN: begin
               if (inv_any_ff) begin
                  vvalid_ff[vslot_ff] <= 1'b0;
               end
            end
            A_EV_FIN: vvalid_ff[vslot_ff] <= 1'b1;
            A_REQ: begin
               rsp_valid_ff <= 1'b1;
               if (cmd.last) begin
                  pend_busy_ff <= 1'b1;
               end
            end
            A_ACC_WR: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
         if (csr_we) begin
            lfsr_ff <= (csr_wdata != 16'd0) ? csr_wdata : 16'd1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (cmd.act)
         A_CAPT: begin
            cur_op_ff    <= req_data.opcode;
            cur_addr_ff  <= req_data.address;
            cur_size_ff  <= req_data.size_code;
            cur_sdata_ff <= req_data.store_data;
            refill_ff    <= req_data.refill_word;
         end
         A_FILL: begin
            if (pend_busy_ff) begin
               pcount_ff <= pcount_ff + 1'b1;
            end
         end
         A_FIN_ROW: begin
            cur_addr_ff  <= paddr_ff;
            cur_op_ff    <= pop_ff;
            cur_size_ff  <= psize_ff;
            cur_sdata_ff <= psv_ff;
            way_ff       <= pway_ff;
            hitresp_ff   <= 1'b0;
         end
         A_ROW_RD: begin
            vhit_ff  <= vmatch;
            vslot_ff <= vmatch_slot;
         end
         A_ROW: begin
            row_ff     <= vld_rdata;
            inv_any_ff <= inv_any;
            way_ff     <= inv_way;
         end
         A_TAG_CMP: begin
            if (sts.tag_match) begin
               way_ff     <= idx_way;
               hitresp_ff <= 1'b1;
            end
         end
         A_PICK: begin
            if (!inv_any_ff) begin
               way_ff <= WW'(lfsr_nx % WAYS);
            end
         end
         A_VPICK: vslot_ff <= vfree_any ? vfree_slot : VSW'(lfsr_nx % VICTIM_ENTRIES);
         A_OT: old_tag_ff <= tag_rdata;
         A_SW_FIN: begin
            hitresp_ff <= 1'b1;
            if (!inv_any_ff) begin
               vaddr_ff[vslot_ff] <= LAW'(old_line_no);
            end
         end
         A_EV_FIN: vaddr_ff[vslot_ff] <= LAW'(old_line_no);
         A_REQ: begin
            if (cmd.last) begin
               paddr_ff  <= cur_addr_ff;
               psv_ff    <= cur_sdata_ff;
               pop_ff    <= cur_op_ff;
               psize_ff  <= cur_size_ff;
               pway_ff   <= way_ff;
               pcount_ff <= '0;
            end
         end
         default: ;
      endcase

      rsp_ff <= '0;
      case (cmd.act)
         A_SW_WR, A_EV_WR: begin
            rsp_ff.kind        <= KIND_WRITE;
            rsp_ff.mem_address <= 64'(old_line_no * LINE_BYTES) + (64'(cmd.idx) << 3);
            rsp_ff.mem_data    <= dat_rdata;
         end
         A_REQ: begin
            rsp_ff.kind        <= KIND_READ;
            rsp_ff.mem_address <= 64'(cur_line_no * LINE_BYTES) + (64'(cmd.idx) << 3);
            rsp_ff.last        <= cmd.last;
         end
         A_ACC_WR: begin
            rsp_ff.kind      <= KIND_RESP;
            rsp_ff.hit       <= hitresp_ff;
            rsp_ff.load_data <= (hitresp_ff && cur_op_ff == OP_LOAD) ? ext : 64'd0;
            rsp_ff.last      <= 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   sadc_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid (
      .clock(clock), .we(vld_we), .waddr(vld_waddr), .wdata(vld_wdata),
      .raddr(vld_raddr), .rdata(vld_rdata)
   );

   sadc_ram #(.WIDTH(TAGW), .DEPTH(SETS * WAYS)) u_tag (
      .clock(clock), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .raddr(tag_raddr), .rdata(tag_rdata)
   );

   sadc_ram #(.WIDTH(64), .DEPTH(SETS * WAYS * WORDS)) u_data (
      .clock(clock), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
      .raddr(dat_raddr), .rdata(dat_rdata)
   );

   sadc_ram #(.WIDTH(64), .DEPTH(VICTIM_ENTRIES * WORDS)) u_victim (
      .clock(clock), .we(vic_we), .waddr(vic_waddr), .wdata(vic_wdata),
      .raddr(vic_raddr), .rdata(vic_rdata)
   );
endmodule

>>> hdl/set_assoc_data_cache_with_victim_unit.sv
// Top level of the set-associative data cache with victim cache.
`timescale 1ns / 1ps
// The cache takes one command at a time: a command is taken when start is high and busy
// is low. Results appear at most one per cycle on rsp_strobe and cannot be held off. The
// last result of a command is on the ports in the cycle in which busy falls, so the next
// command can be taken in that cycle. After reset a clearing pass over the valid memory
// keeps busy high. An access scans the ways one by one through the single tag memory
// port. An access taken while a refill is pending is dropped. The last refill word of a
// line installs the line and then completes the pending access. Sizes are powers of two.
module set_assoc_data_cache_with_victim_unit import sadc_pkg::*; #(
   parameter int SETS           = 32,
   parameter int WAYS           = 32,
   parameter int LINE_BYTES     = 16,
   parameter int VICTIM_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   sadc_ctrl #(.SETS(SETS), .WAYS(WAYS), .WORDS(LINE_BYTES / 8)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   sadc_dpath #(
      .SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .VICTIM_ENTRIES(VICTIM_ENTRIES)
   ) u_dpath (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts), .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );
endmodule

>>> hdl/sadc_chk.sv
// Port-level checks of the data cache, bound to the top level.
`timescale 1ns / 1ps
module sadc_chk import sadc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);
   // A transfer in makes the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accepted command");

   a_resp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind == KIND_RESP |->
         rsp_data.mem_address == 64'd0 && rsp_data.mem_data == 64'd0 && rsp_data.last)
      else $error("access response carries memory fields");

   a_mem_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.kind == KIND_WRITE || rsp_data.kind == KIND_READ) |->
         !rsp_data.hit && rsp_data.load_data == 64'd0 && rsp_data.mem_address[2:0] == 3'd0)
      else $error("memory transfer malformed");

   a_read_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind == KIND_READ |-> rsp_data.mem_data == 64'd0)
      else $error("read request carries data");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe) else $error("result right after reset");
endmodule

bind set_assoc_data_cache_with_victim_unit sadc_chk u_sadc_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);

>>> verif/set_assoc_data_cache_with_victim_unit_tb.sv
// Testbench for the set-associative data cache with victim cache: directed table plus random traffic.
`timescale 1ns / 1ps
module set_assoc_data_cache_with_victim_unit_tb;
   import sadc_pkg::*;

   localparam int SETS = 32;
   localparam int WAYS = 32;
   localparam int VICS = 8;
   localparam int LINES = SETS * WAYS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 120;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we;
   logic [15:0] csr_wdata;

   set_assoc_data_cache_with_victim_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Shadow copy of the cache state.
   logic        l1_valid [LINES];
   logic [54:0] l1_tag [LINES];
   logic [63:0] l1_data [LINES][2];
   logic        vc_valid [VICS];
   logic [59:0] vc_line [VICS];
   logic [63:0] vc_data [VICS][2];
   logic [15:0] lfsr_state;
   logic [63:0] fill_addr;
   logic [63:0] fill_store;
   logic        fill_busy;
   logic [1:0]  fill_op;
   logic [1:0]  fill_size;
   int          fill_line;
   int          fill_count;

   rsp_type step_rsps[$];
   rsp_type expected_rsps[$];
   int error_count = 0;
   int idle_cycles = 0;

   function automatic int lfsr_draw(int n);
      logic shifted_out;
      shifted_out = lfsr_state[0];
      lfsr_state = lfsr_state >> 1;
      if (shifted_out) lfsr_state = lfsr_state ^ LFSR_TAPS;
      return int'(lfsr_state) % n;
   endfunction

   function automatic logic [63:0] line_access(int line, logic [1:0] op, logic [1:0] size,
                                               logic [63:0] addr, logic [63:0] value);
      int bytes;
      logic [3:0] offs;
      int sh;
      logic [63:0] mask;
      bytes = 1 << size;
      offs = addr[3:0] & ~4'(bytes - 1);
      sh = int'(offs[2:0]) * 8;
      mask = (bytes == 8) ? '1 : ((64'd1 << (bytes * 8)) - 1);
      if (op == OP_LOAD) return (l1_data[line][offs[3]] >> sh) & mask;
      l1_data[line][offs[3]] = (l1_data[line][offs[3]] & ~(mask << sh)) | ((value & mask) << sh);
      return '0;
   endfunction

   function automatic int choose_way(int set, output logic displaced);
      for (int w = 0; w < WAYS; w++) begin
         if (!l1_valid[set * WAYS + w]) begin
            displaced = 1'b0;
            return set * WAYS + w;
         end
      end
      displaced = 1'b1;
      return set * WAYS + lfsr_draw(WAYS);
   endfunction

   function automatic void push_rsp(logic [1:0] kind, logic hit, logic [63:0] ld,
                                    logic [63:0] ma, logic [63:0] md);
      rsp_type r;
      r = '{kind: kind, hit: hit, load_data: ld, mem_address: ma, mem_data: md, last: 1'b0};
      step_rsps.push_back(r);
   endfunction

   function automatic void cache_reset();
      for (int i = 0; i < LINES; i++) l1_valid[i] = 1'b0;
      for (int v = 0; v < VICS; v++) vc_valid[v] = 1'b0;
      lfsr_state = 16'd1;
      fill_busy = 1'b0;
      fill_addr = '0;
      fill_store = '0;
   endfunction

   // Updates the shadow state for one accepted transfer and leaves its results in step_rsps.
   function automatic void cache_step(req_type r);
      logic [59:0] line_no;
      logic [59:0] old_line;
      logic [54:0] tag;
      int set, line, slot;
      logic displaced;
      logic [63:0] ld;
      logic [63:0] saved [2];
      step_rsps.delete();
      if (r.opcode == OP_REFILL) begin
         if (!fill_busy) return;
         l1_data[fill_line][fill_count % 2] = r.refill_word;
         fill_count++;
         if (fill_count < 2) return;
         l1_valid[fill_line] = 1'b1;
         l1_tag[fill_line] = fill_addr[63:9];
         if (fill_op != OP_LOAD)
            ld = line_access(fill_line, fill_op, fill_size, fill_addr, fill_store);
         fill_busy = 1'b0;
         push_rsp(KIND_RESP, 1'b0, '0, '0, '0);
         step_rsps[$].last = 1'b1;
         return;
      end
      if (fill_busy) return;
      line_no = r.address[63:4];
      set = int'(line_no[4:0]);
      tag = line_no[59:5];
      for (int w = 0; w < WAYS; w++) begin
         line = set * WAYS + w;
         if (l1_valid[line] && l1_tag[line] == tag) begin
            ld = line_access(line, r.opcode, r.size_code, r.address, r.store_data);
            push_rsp(KIND_RESP, 1'b1, ld, '0, '0);
            step_rsps[$].last = 1'b1;
            return;
         end
      end
      for (int v = 0; v < VICS; v++) begin
         if (vc_valid[v] && vc_line[v] == line_no) begin
            saved = vc_data[v];
            line = choose_way(set, displaced);
            if (displaced) begin
               old_line = {l1_tag[line], 5'(set)};
               for (int i = 0; i < 2; i++)
                  push_rsp(KIND_WRITE, 1'b0, '0, {old_line, 4'h0} + 64'(8 * i), l1_data[line][i]);
               vc_line[v] = old_line;
               vc_data[v] = l1_data[line];
            end else begin
               vc_valid[v] = 1'b0;
            end
            l1_data[line] = saved;
            l1_valid[line] = 1'b1;
            l1_tag[line] = tag;
            ld = line_access(line, r.opcode, r.size_code, r.address, r.store_data);
            push_rsp(KIND_RESP, 1'b1, ld, '0, '0);
            step_rsps[$].last = 1'b1;
            return;
         end
      end
      line = choose_way(set, displaced);
      if (displaced) begin
         slot = VICS;
         for (int v = 0; v < VICS; v++) begin
            if (!vc_valid[v] && slot == VICS) slot = v;
         end
         if (slot == VICS) slot = lfsr_draw(VICS);
         old_line = {l1_tag[line], 5'(set)};
         vc_valid[slot] = 1'b1;
         vc_line[slot] = old_line;
         vc_data[slot] = l1_data[line];
         for (int i = 0; i < 2; i++)
            push_rsp(KIND_WRITE, 1'b0, '0, {old_line, 4'h0} + 64'(8 * i), l1_data[line][i]);
         l1_valid[line] = 1'b0;
      end
      for (int i = 0; i < 2; i++)
         push_rsp(KIND_READ, 1'b0, '0, {line_no, 4'h0} + 64'(8 * i), '0);
      step_rsps[$].last = 1'b1;
      fill_addr = r.address;
      fill_store = r.store_data;
      fill_busy = 1'b1;
      fill_op = r.opcode;
      fill_size = r.size_code;
      fill_line = line;
      fill_count = 0;
   endfunction

   // Result checker; the receiver never stalls.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.hit !== want.hit ||
                rsp_data.load_data !== want.load_data ||
                rsp_data.mem_address !== want.mem_address ||
                rsp_data.mem_data !== want.mem_data || rsp_data.last !== want.last) begin
               $display("%0t: result mismatch: expected %p, actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("set_assoc_data_cache_with_victim_unit_tb: FAIL");
         $finish;
      end
   end

   // One transfer; typed rows replace the predicted results with the given ones.
   task automatic send(req_type r, logic typed, int n_typed, rsp_type t0, rsp_type t1);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      cache_step(r);
      if (typed) begin
         if (n_typed > 0) expected_rsps.push_back(t0);
         if (n_typed > 1) expected_rsps.push_back(t1);
      end else begin
         foreach (step_rsps[i]) expected_rsps.push_back(step_rsps[i]);
      end
   endtask

   task automatic pause_random(logic allow);
      if (allow && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_seed(logic [15:0] seed);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= seed;
      @(posedge clock);
      csr_we <= 1'b0;
      lfsr_state = (seed == 16'd0) ? 16'd1 : seed;
   endtask

   function automatic req_type random_req();
      req_type r;
      int roll;
      r.opcode = 2'($urandom_range(0, 2));
      r.size_code = 2'($urandom_range(0, 3));
      r.store_data = {$urandom, $urandom};
      r.refill_word = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      // Most accesses crowd one set so that ways fill up and lines cycle through the victims.
      if (roll < 75)
         r.address = {51'($urandom_range(0, 44)), 5'd5, 4'($urandom_range(0, 15)), 4'h0} >> 4;
      else if (roll < 85)
         r.address = {50'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)), 4'($urandom)};
      else
         r.address = {$urandom, $urandom};
      if (fill_busy ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0))
         r.opcode = OP_REFILL;
      return r;
   endfunction

   typedef struct {
      req_type req;
      logic    typed;
      int      n_typed;
      rsp_type t0;
      rsp_type t1;
   } stim_row;

   localparam logic [63:0] W0 = 64'h8877_6655_4433_2211;
   localparam logic [63:0] W1 = 64'hF0E1_D2C3_B4A5_9687;
   localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFF8;

   stim_row directed [] = '{
      '{'{OP_REFILL, '1, 2'd3, '1, '1}, 1'b1, 0, '0, '0},
      '{'{OP_LOAD, 64'h0, 2'd0, '0, '0}, 1'b1, 2,
        '{KIND_READ, 1'b0, '0, 64'h0, '0, 1'b0}, '{KIND_READ, 1'b0, '0, 64'h8, '0, 1'b1}},
      '{'{OP_STORE, 64'h40, 2'd3, '1, '0}, 1'b1, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, W0}, 1'b1, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, W1}, 1'b1, 1, '{KIND_RESP, 1'b0, '0, '0, '0, 1'b1}, '0},
      '{'{OP_LOAD, 64'h0, 2'd3, '0, '0}, 1'b1, 1, '{KIND_RESP, 1'b1, W0, '0, '0, 1'b1}, '0},
      '{'{OP_LOAD, 64'h7, 2'd3, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_STORE, 64'h8, 2'd0, '1, '0}, 1'b0, 0, '0, '0},
      '{'{OP_MODIFY, 64'hB, 2'd1, 64'h1234_5678_9ABC_DEF0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_STORE, 64'h4, 2'd2, 64'hDEAD_BEEF_0BAD_F00D, '0}, 1'b0, 0, '0, '0},
      '{'{OP_LOAD, 64'hF, 2'd0, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_LOAD, 64'hC, 2'd2, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_LOAD, 64'h8, 2'd3, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_LOAD, 64'h2, 2'd1, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_STORE, '1, 2'd3, '1, '0}, 1'b1, 2,
        '{KIND_READ, 1'b0, '0, TOP - 64'h8, '0, 1'b0}, '{KIND_READ, 1'b0, '0, TOP, '0, 1'b1}},
      '{'{OP_LOAD, 64'h0, 2'd0, '0, '0}, 1'b1, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, '0}, 1'b1, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, '0}, 1'b1, 1, '{KIND_RESP, 1'b0, '0, '0, '0, 1'b1}, '0},
      '{'{OP_LOAD, TOP, 2'd3, '0, '0}, 1'b1, 1, '{KIND_RESP, 1'b1, '1, '0, '0, 1'b1}, '0},
      '{'{OP_LOAD, 64'hFFFF_FFFF_FFFF_FFF0, 2'd3, '0, '0}, 1'b1, 1,
        '{KIND_RESP, 1'b1, 64'h0, '0, '0, 1'b1}, '0},
      '{'{OP_LOAD, 64'h10, 2'd3, '0, '0}, 1'b0, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, '1}, 1'b0, 0, '0, '0},
      '{'{OP_REFILL, '0, 2'd0, '0, 64'h5A5A_A5A5_0F0F_F0F0}, 1'b0, 0, '0, '0}
   };

   initial begin
      logic [15:0] seeds [3];
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = 16'd0;
      reset = 1'b1;
      cache_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send(directed[i].req, directed[i].typed, directed[i].n_typed,
              directed[i].t0, directed[i].t1);
         pause_random(1'b1);
      end

      // The seed of zero must behave as a seed of one.
      seeds[0] = 16'hFFFF;
      seeds[1] = 16'd0;
      seeds[2] = 16'($urandom_range(1, 65535));
      for (int p = 0; p < 3; p++) begin
         write_seed(seeds[p]);
         for (int i = 0; i < 45; i++) begin
            send(random_req(), 1'b0, 0, '0, '0);
            pause_random(!(p == 2 && i >= 30));
         end
      end
      start <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("set_assoc_data_cache_with_victim_unit_tb: PASS");
      end else begin
         $display("set_assoc_data_cache_with_victim_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
